>>> src/dcr_pkg.sv
// Shared types, constants and register codes for the depth colormap block.
// No dependencies; every other file imports this package.

package dcr_pkg;

    // Frame geometry
    localparam int MAX_DIM     = 1024;
    localparam int DIM_W       = 11;                  // register width of a dimension
    localparam int CNT_W       = $clog2(MAX_DIM);     // row / column counter width
    localparam int DEST_W      = 20;
    localparam int DEPTH_W     = 16;
    localparam int COLOR_W     = 32;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DIM_W;
    localparam int ORIENT_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIENTATION   = 2'd0,
        CFG_SOURCE_WIDTH  = 2'd1,
        CFG_SOURCE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_LANDSCAPE = 2'd0,
        ORIENT_CW        = 2'd1,
        ORIENT_CCW       = 2'd2
    } orient_t;

    localparam logic [ORIENT_W-1:0] ORIENT_RESET = ORIENT_LANDSCAPE;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 11'd480;

    // Palette breakpoints
    localparam logic [DEPTH_W-1:0] DEPTH_BLACK_END = 16'h0190;
    localparam logic [DEPTH_W-1:0] DEPTH_SEG1_END  = 16'h0400;
    localparam logic [DEPTH_W-1:0] DEPTH_SEG2_END  = 16'h0600;
    localparam logic [DEPTH_W-1:0] DEPTH_SEG3_END  = 16'h0800;
    localparam logic [DEPTH_W-1:0] DEPTH_SEG4_END  = 16'h0C00;
    localparam logic [DEPTH_W-1:0] DEPTH_FAR       = 16'h1000;

    localparam logic [7:0]         CHAN_FULL    = 8'hFF;
    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] FAR_RED      = 32'hFFFF_0000;

    // floor(q / 39) == (q * RECIP_39) >> RECIP_SHIFT for q < 2^14
    localparam logic [14:0] RECIP_39    = 15'd26887;
    localparam int          RECIP_SHIFT = 20;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [ORIENT_W-1:0] orientation;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } cfg_t;

    // Source position of one pixel
    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;
    } pos_t;

endpackage

>>> src/dcr_if.sv
// Stream interfaces for depth pixels in and colored pixels out.
// Depends on dcr_pkg for field widths.

interface dcr_in_if import dcr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth;

    modport source (output valid, output depth, input ready);
    modport sink   (input valid, input depth, output ready);
endinterface

interface dcr_out_if import dcr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color;
    logic [DEST_W-1:0]  dest_index;
    logic               frame_end;

    modport source (output valid, output color, output dest_index, output frame_end,
                    input ready);
    modport sink   (input valid, input color, input dest_index, input frame_end,
                    output ready);
endinterface

>>> src/dcr_cfg_regs.sv
// Configuration registers with clamping of the frame dimensions.
// Depends on dcr_pkg.

module dcr_cfg_regs import dcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic [ORIENT_W-1:0] orientation_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= ORIENT_RESET;
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIENTATION:   orientation_reg <= cfg_data[ORIENT_W-1:0];
                CFG_SOURCE_WIDTH:  width_reg       <= cfg_data;
                CFG_SOURCE_HEIGHT: height_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero acts as one, oversize acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > DIM_MAX)
            res = DIM_MAX;
        else
            res = v;
        return res;
    endfunction

    always_comb
    begin
        cfg.orientation = orientation_reg;
        cfg.width       = clamp_dim(width_reg);
        cfg.height      = clamp_dim(height_reg);
    end

endmodule

>>> src/dcr_pos_counter.sv
// Row and column counters that tag each accepted pixel with its source position.
// Depends on dcr_pkg.

module dcr_pos_counter import dcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic advance,
    output pos_t pos
);

    logic [CNT_W-1:0] outer_count_reg, outer_count_next;
    logic [CNT_W-1:0] inner_count_reg, inner_count_next;
    logic             row_end;

    // Position of the pixel being accepted; out-of-frame counters restart the frame
    always_comb
    begin
        if ((DIM_W'(outer_count_reg) >= cfg.height) || (DIM_W'(inner_count_reg) >= cfg.width))
        begin
            pos.row = '0;
            pos.col = '0;
        end
        else
        begin
            pos.row = outer_count_reg;
            pos.col = inner_count_reg;
        end
        row_end  = (DIM_W'(pos.col) == cfg.width - DIM_W'(1));
        pos.last = row_end && (DIM_W'(pos.row) == cfg.height - DIM_W'(1));
    end

    // Advance to the next pixel in raster order
    always_comb
    begin
        if (row_end)
        begin
            inner_count_next = '0;
            outer_count_next = pos.last ? '0 : pos.row + CNT_W'(1);
        end
        else
        begin
            inner_count_next = pos.col + CNT_W'(1);
            outer_count_next = pos.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_count_reg <= '0;
            inner_count_reg <= '0;
        end
        else if (advance)
        begin
            outer_count_reg <= outer_count_next;
            inner_count_reg <= inner_count_next;
        end
    end

endmodule

>>> src/dcr_pixel_map.sv
// Combinational palette lookup and destination index for one registered pixel.
// Depends on dcr_pkg.

module dcr_pixel_map import dcr_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [DEPTH_W-1:0] depth,
    input  logic [CNT_W-1:0]   row,
    input  logic [CNT_W-1:0]   col,
    output logic [COLOR_W-1:0] color,
    output logic [DEST_W-1:0]  dest_index
);

    // ---------------- palette ----------------
    logic [DEPTH_W-1:0] off1, off2, off4;
    logic [9:0]         x1, x4;
    logic [8:0]         x2;
    logic [17:0]        p1, p4;
    logic [16:0]        p2;
    logic [28:0]        m1;
    logic [7:0]         ramp1, ramp2, ramp4;

    always_comb
    begin
        off1 = depth - DEPTH_BLACK_END;
        off2 = depth - ((depth < DEPTH_SEG2_END) ? DEPTH_SEG1_END : DEPTH_SEG2_END);
        off4 = depth - ((depth < DEPTH_SEG4_END) ? DEPTH_SEG3_END : DEPTH_SEG4_END);
        x1   = off1[9:0];
        x2   = off2[8:0];
        x4   = off4[9:0];

        // 255*x as a shift and subtract
        p1 = (18'(x1) << 8) - 18'(x1);
        p2 = (17'(x2) << 8) - 17'(x2);
        p4 = (18'(x4) << 8) - 18'(x4);

        // segment of 624 = 16 * 39: shift, then reciprocal multiply
        m1    = 29'(p1[17:4]) * 29'(RECIP_39);
        ramp1 = m1[RECIP_SHIFT+7:RECIP_SHIFT];
        ramp2 = p2[16:9];
        ramp4 = p4[17:10];

        if (depth >= DEPTH_FAR)
            color = FAR_RED;
        else if (depth < DEPTH_BLACK_END)
            color = ALPHA_OPAQUE;
        else if (depth < DEPTH_SEG1_END)
            color = ALPHA_OPAQUE | {8'h00, CHAN_FULL - ramp1, 8'h00, CHAN_FULL};
        else if (depth < DEPTH_SEG2_END)
            color = ALPHA_OPAQUE | {8'h00, 8'h00, ramp2, CHAN_FULL};
        else if (depth < DEPTH_SEG3_END)
            color = ALPHA_OPAQUE | {8'h00, 8'h00, CHAN_FULL, CHAN_FULL - ramp2};
        else if (depth < DEPTH_SEG4_END)
            color = ALPHA_OPAQUE | {8'h00, ramp4, CHAN_FULL, 8'h00};
        else
            color = ALPHA_OPAQUE | {8'h00, CHAN_FULL, CHAN_FULL - ramp4, 8'h00};
    end

    // ---------------- destination index ----------------
    // One multiply-add: mul_a * mul_b + addend, operands chosen by orientation
    logic [DIM_W-1:0]       w_m1_c;
    logic [DIM_W-1:0]       h_m1_r;
    logic [CNT_W-1:0]       mul_a;
    logic [DIM_W-1:0]       mul_b;
    logic [DIM_W-1:0]       addend;
    logic [CNT_W+DIM_W-1:0] prod;
    logic [CNT_W+DIM_W:0]   sum;

    always_comb
    begin
        w_m1_c = cfg.width - DIM_W'(1) - DIM_W'(col);
        h_m1_r = cfg.height - DIM_W'(1) - DIM_W'(row);
        case (cfg.orientation)
            ORIENT_CW:
            begin
                mul_a  = col;
                mul_b  = cfg.height;
                addend = h_m1_r;
            end
            ORIENT_CCW:
            begin
                mul_a  = w_m1_c[CNT_W-1:0];
                mul_b  = cfg.height;
                addend = DIM_W'(row);
            end
            default:
            begin
                mul_a  = row;
                mul_b  = cfg.width;
                addend = DIM_W'(col);
            end
        endcase
        prod       = (CNT_W+DIM_W)'(mul_a) * (CNT_W+DIM_W)'(mul_b);
        sum        = (CNT_W+DIM_W+1)'(prod) + (CNT_W+DIM_W+1)'(addend);
        dest_index = sum[DEST_W-1:0];
    end

endmodule

>>> src/depth_colormap_rotate.sv
// Top level: depth pixel stream to ARGB color with oriented destination index.
// Depends on dcr_pkg, dcr_if, dcr_cfg_regs, dcr_pos_counter, dcr_pixel_map.
//
//   channel   dir  fields                              transfer
//   pix_in    in   depth[15:0]                         valid & ready
//   pix_out   out  color[31:0] dest_index[19:0]        valid & ready
//                  frame_end
//   cfg_*     in   cfg_index[1:0] cfg_data[10:0]       cfg_we
//
// Two register stages: an input register (depth plus its source row/column)
// and a result register, with the palette and one multiply-add between them.
// One pixel is taken every cycle while the result side
// keeps up. A stall on pix_out fills both stages before pix_in.ready drops.
// Reset clears the valid flags and position counters and restores the config.

module depth_colormap_rotate import dcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dcr_in_if.sink                pix_in,
    dcr_out_if.source             pix_out
);

    cfg_t cfg;
    pos_t pos;

    logic s1_valid_reg;
    logic [DEPTH_W-1:0] s1_depth_reg;
    logic [CNT_W-1:0]   s1_row_reg;
    logic [CNT_W-1:0]   s1_col_reg;
    logic               s1_last_reg;

    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [DEST_W-1:0]  out_dest_reg;
    logic               out_last_reg;

    logic [COLOR_W-1:0] map_color;
    logic [DEST_W-1:0]  map_dest;

    logic out_free;
    logic s1_move;
    logic in_take;

    dcr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcr_pos_counter u_pos
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (in_take),
        .pos     (pos)
    );

    dcr_pixel_map u_map
    (
        .cfg        (cfg),
        .depth      (s1_depth_reg),
        .row        (s1_row_reg),
        .col        (s1_col_reg),
        .color      (map_color),
        .dest_index (map_dest)
    );

    // Pipeline flow control
    always_comb
    begin
        out_free     = !out_valid_reg || pix_out.ready;
        s1_move      = s1_valid_reg && out_free;
        pix_in.ready = !s1_valid_reg || out_free;
        in_take      = pix_in.valid && pix_in.ready;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_in.ready)
                s1_valid_reg <= pix_in.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_depth_reg <= pix_in.depth;
            s1_row_reg   <= pos.row;
            s1_col_reg   <= pos.col;
            s1_last_reg  <= pos.last;
        end
        if (s1_move)
        begin
            out_color_reg <= map_color;
            out_dest_reg  <= map_dest;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.color      = out_color_reg;
    assign pix_out.dest_index = out_dest_reg;
    assign pix_out.frame_end  = out_last_reg;

endmodule
